// ===== src/top_k_chebyshev_point_selector_defines.svh =====
// Assertion macros for the top-k Chebyshev point selector RTL.
`ifndef TOP_K_CHEBYSHEV_POINT_SELECTOR_DEFINES_SVH
`define TOP_K_CHEBYSHEV_POINT_SELECTOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define TKCPS_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("tkcps: implication check failed");
`define TKCPS_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("tkcps: next-cycle check failed");
`else
`define TKCPS_ASSERT_IMP(label, clk, rst_n, a, c)
`define TKCPS_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== src/tkcps_pkg.sv =====
// Types, constants and norm functions for the top-k Chebyshev point selector.
package tkcps_pkg;

    localparam int MAX_ROOTS  = 16;
    localparam int COORD_BITS = 16;
    localparam int CFG_BITS   = 5;
    localparam int ADDR_BITS  = (MAX_ROOTS > 1) ? $clog2(MAX_ROOTS) : 1;
    localparam int FILL_BITS  = $clog2(MAX_ROOTS + 1);
    localparam int ENTRY_BITS = 2 * COORD_BITS;

    localparam logic [CFG_BITS-1:0] ROOT_COUNT_RESET = CFG_BITS'(4);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS-1:0]        norm_t;
    typedef logic [ADDR_BITS-1:0]         addr_t;
    typedef logic [FILL_BITS-1:0]         fill_t;
    typedef logic [ENTRY_BITS-1:0]        entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_EVICT,
        S_SCAN,
        S_FLUSH_RD,
        S_FLUSH_EM
    } state_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   is_root;
        logic   run_end;
    } result_t;

    typedef struct packed {
        logic   we;
        addr_t  waddr;
        entry_t wdata;
        logic   re;
        addr_t  raddr;
    } ram_req_t;

    function automatic norm_t magnitude(coord_t v);
        norm_t u;
        u = norm_t'(v);
        return v[COORD_BITS-1] ? (~u + norm_t'(1)) : u;
    endfunction

    function automatic norm_t cheb_norm(coord_t x, coord_t y);
        norm_t ax;
        norm_t ay;
        ax = magnitude(x);
        ay = magnitude(y);
        return (ax > ay) ? ax : ay;
    endfunction

    // A root count above the table depth behaves as the table depth.
    function automatic fill_t limit_of(logic [CFG_BITS-1:0] rc);
        if (int'(rc) > MAX_ROOTS)
        begin
            return fill_t'(MAX_ROOTS);
        end
        return fill_t'(rc);
    endfunction

endpackage

// ===== src/tkcps_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module tkcps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                  wdata,
    input  logic                              re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/tkcps_ctrl.sv =====
// Sequencer for the selector: fill, evict, rescan of the smallest norm, and flush.
`include "top_k_chebyshev_point_selector_defines.svh"

module tkcps_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                point_valid,
    output logic                                point_ready,
    input  tkcps_pkg::coord_t                   point_x,
    input  tkcps_pkg::coord_t                   point_y,
    input  logic                                final_point,
    input  logic [tkcps_pkg::CFG_BITS-1:0]      root_count,
    output logic                                emit_valid,
    input  logic                                emit_ready,
    output tkcps_pkg::result_t                  emit,
    output tkcps_pkg::ram_req_t                 ram_req,
    input  tkcps_pkg::entry_t                   ram_rdata
);

    tkcps_pkg::state_t state_reg, state_next;
    tkcps_pkg::coord_t px_reg, px_next;
    tkcps_pkg::coord_t py_reg, py_next;
    logic              final_reg, final_next;
    tkcps_pkg::norm_t  pnorm_reg, pnorm_next;
    tkcps_pkg::fill_t  fill_reg, fill_next;
    tkcps_pkg::addr_t  small_idx_reg, small_idx_next;
    tkcps_pkg::norm_t  small_norm_reg, small_norm_next;
    tkcps_pkg::fill_t  idx_reg, idx_next;
    logic              cmp_valid_reg, cmp_valid_next;
    tkcps_pkg::addr_t  cmp_idx_reg, cmp_idx_next;

    tkcps_pkg::fill_t  limit;
    logic              take_fill;
    logic              evict;
    logic              scan_rd;
    logic              flush_last;
    tkcps_pkg::coord_t rd_x;
    tkcps_pkg::coord_t rd_y;
    tkcps_pkg::norm_t  rd_norm;

    assign limit      = tkcps_pkg::limit_of(root_count);
    assign take_fill  = fill_reg < limit;
    assign evict      = pnorm_reg > small_norm_reg;
    assign scan_rd    = idx_reg < fill_reg;
    assign flush_last = (idx_reg + tkcps_pkg::fill_t'(1)) == fill_reg;
    assign rd_x       = ram_rdata[tkcps_pkg::ENTRY_BITS-1 -: tkcps_pkg::COORD_BITS];
    assign rd_y       = ram_rdata[tkcps_pkg::COORD_BITS-1:0];
    assign rd_norm    = tkcps_pkg::cheb_norm(rd_x, rd_y);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tkcps_pkg::S_IDLE:
            begin
                if (point_valid)
                begin
                    state_next = tkcps_pkg::S_EVAL;
                end
            end
            tkcps_pkg::S_EVAL:
            begin
                if (take_fill)
                begin
                    state_next = final_reg ? tkcps_pkg::S_FLUSH_RD : tkcps_pkg::S_IDLE;
                end
                else if (fill_reg == '0)
                begin
                    if (emit_ready)
                    begin
                        state_next = tkcps_pkg::S_IDLE;
                    end
                end
                else if (evict)
                begin
                    state_next = tkcps_pkg::S_EVICT;
                end
                else if (emit_ready)
                begin
                    state_next = final_reg ? tkcps_pkg::S_FLUSH_RD : tkcps_pkg::S_IDLE;
                end
            end
            tkcps_pkg::S_EVICT:
            begin
                if (emit_ready)
                begin
                    state_next = tkcps_pkg::S_SCAN;
                end
            end
            tkcps_pkg::S_SCAN:
            begin
                if (!scan_rd && !cmp_valid_reg)
                begin
                    state_next = final_reg ? tkcps_pkg::S_FLUSH_RD : tkcps_pkg::S_IDLE;
                end
            end
            tkcps_pkg::S_FLUSH_RD:
            begin
                state_next = tkcps_pkg::S_FLUSH_EM;
            end
            tkcps_pkg::S_FLUSH_EM:
            begin
                if (emit_ready)
                begin
                    state_next = flush_last ? tkcps_pkg::S_IDLE : tkcps_pkg::S_FLUSH_RD;
                end
            end
            default:
            begin
                state_next = tkcps_pkg::S_IDLE;
            end
        endcase
    end

    // Handshake, result and memory port outputs.
    always_comb
    begin
        point_ready   = 1'b0;
        emit_valid    = 1'b0;
        emit.x        = px_reg;
        emit.y        = py_reg;
        emit.is_root  = 1'b0;
        emit.run_end  = 1'b0;
        ram_req.we    = 1'b0;
        ram_req.waddr = fill_reg[tkcps_pkg::ADDR_BITS-1:0];
        ram_req.wdata = {px_reg, py_reg};
        ram_req.re    = 1'b0;
        ram_req.raddr = idx_reg[tkcps_pkg::ADDR_BITS-1:0];
        case (state_reg)
            tkcps_pkg::S_IDLE:
            begin
                point_ready = 1'b1;
            end
            tkcps_pkg::S_EVAL:
            begin
                if (take_fill)
                begin
                    ram_req.we = 1'b1;
                end
                else if (fill_reg == '0)
                begin
                    emit_valid   = 1'b1;
                    emit.run_end = 1'b1;
                end
                else if (evict)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = small_idx_reg;
                end
                else
                begin
                    emit_valid   = 1'b1;
                    emit.run_end = !final_reg;
                end
            end
            tkcps_pkg::S_EVICT:
            begin
                // The displaced root leaves as a leaf; the new point takes its slot.
                emit_valid    = 1'b1;
                emit.x        = rd_x;
                emit.y        = rd_y;
                emit.run_end  = !final_reg;
                ram_req.we    = emit_ready;
                ram_req.waddr = small_idx_reg;
            end
            tkcps_pkg::S_SCAN:
            begin
                ram_req.re = scan_rd;
            end
            tkcps_pkg::S_FLUSH_RD:
            begin
                ram_req.re = 1'b1;
            end
            tkcps_pkg::S_FLUSH_EM:
            begin
                emit_valid   = 1'b1;
                emit.x       = rd_x;
                emit.y       = rd_y;
                emit.is_root = 1'b1;
                emit.run_end = flush_last;
            end
            default:
            begin
                point_ready = 1'b0;
            end
        endcase
    end

    // Datapath registers.
    always_comb
    begin
        px_next         = px_reg;
        py_next         = py_reg;
        final_next      = final_reg;
        pnorm_next      = pnorm_reg;
        fill_next       = fill_reg;
        small_idx_next  = small_idx_reg;
        small_norm_next = small_norm_reg;
        idx_next        = idx_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        case (state_reg)
            tkcps_pkg::S_IDLE:
            begin
                if (point_valid)
                begin
                    px_next    = point_x;
                    py_next    = point_y;
                    final_next = final_point;
                    pnorm_next = tkcps_pkg::cheb_norm(point_x, point_y);
                end
            end
            tkcps_pkg::S_EVAL:
            begin
                // Appending only needs a compare with the new entry: it has the
                // highest index, so it wins only on a strictly smaller norm.
                if (take_fill)
                begin
                    fill_next = fill_reg + tkcps_pkg::fill_t'(1);
                    if (fill_reg == '0 || pnorm_reg < small_norm_reg)
                    begin
                        small_norm_next = pnorm_reg;
                        small_idx_next  = fill_reg[tkcps_pkg::ADDR_BITS-1:0];
                    end
                end
            end
            tkcps_pkg::S_SCAN:
            begin
                cmp_valid_next = scan_rd;
                cmp_idx_next   = idx_reg[tkcps_pkg::ADDR_BITS-1:0];
                if (scan_rd)
                begin
                    idx_next = idx_reg + tkcps_pkg::fill_t'(1);
                end
                else if (!cmp_valid_reg)
                begin
                    idx_next = '0;
                end
                if (cmp_valid_reg && (cmp_idx_reg == '0 || rd_norm < small_norm_reg))
                begin
                    small_norm_next = rd_norm;
                    small_idx_next  = cmp_idx_reg;
                end
            end
            tkcps_pkg::S_FLUSH_EM:
            begin
                if (emit_ready)
                begin
                    if (flush_last)
                    begin
                        idx_next        = '0;
                        fill_next       = '0;
                        small_idx_next  = '0;
                        small_norm_next = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + tkcps_pkg::fill_t'(1);
                    end
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tkcps_pkg::S_IDLE;
            fill_reg       <= '0;
            small_idx_reg  <= '0;
            small_norm_reg <= '0;
            idx_reg        <= '0;
            cmp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            small_idx_reg  <= small_idx_next;
            small_norm_reg <= small_norm_next;
            idx_reg        <= idx_next;
            cmp_valid_reg  <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg      <= px_next;
        py_reg      <= py_next;
        final_reg   <= final_next;
        pnorm_reg   <= pnorm_next;
        cmp_idx_reg <= cmp_idx_next;
    end

    `TKCPS_ASSERT_IMP(a_small_in_table, clk, rst_n,
        state_reg == tkcps_pkg::S_IDLE && fill_reg != '0,
        tkcps_pkg::fill_t'(small_idx_reg) < fill_reg)
    `TKCPS_ASSERT_IMP(a_no_rw_overlap, clk, rst_n, ram_req.we, !ram_req.re)
    `TKCPS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n,
        point_valid && point_ready, !point_ready)
    `TKCPS_ASSERT_IMP(a_fill_drop_clears, clk, rst_n,
        fill_reg < $past(fill_reg), fill_reg == '0 && small_norm_reg == '0)

endmodule

// ===== src/top_k_chebyshev_point_selector.sv =====
// Top level of the streaming top-k Chebyshev point selector.
//
// Points come in on the point request channel (point_valid/point_ready) with
// final_point marking the last point of a run. Results leave on the result
// channel (result_valid/result_ready) from an output register: leaves while
// the run streams, then every kept root (is_root = 1) after the final point.
// run_end flags the last result caused by one input point.
// The user must write the root count register via cfg_wr_en/cfg_wr_data only
// while idle; the block does not enforce this. A point is taken only while
// the sequencer is idle. A point that is stored while the table fills, or
// that leaves as a leaf, is evaluated before the next point is let in; such
// a leaf goes from the point registers to the output register. An eviction
// reads the displaced root from the table RAM into the output register and
// holds the input during the rescan that reads each kept entry through the
// table RAM's single read port and one comparator. The final flush reads and
// then emits each kept root. A stalled receiver holds the output register and
// the sequencer waits. Reset empties the table and sets the root count to 4.
module top_k_chebyshev_point_selector (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           point_valid,
    output logic                           point_ready,
    input  tkcps_pkg::coord_t              point_x,
    input  tkcps_pkg::coord_t              point_y,
    input  logic                           final_point,
    output logic                           result_valid,
    input  logic                           result_ready,
    output tkcps_pkg::coord_t              out_x,
    output tkcps_pkg::coord_t              out_y,
    output logic                           is_root,
    output logic                           run_end,
    input  logic                           cfg_wr_en,
    input  logic [tkcps_pkg::CFG_BITS-1:0] cfg_wr_data
);

    logic [tkcps_pkg::CFG_BITS-1:0] root_count_reg;
    logic                           result_valid_reg, result_valid_next;
    tkcps_pkg::result_t             result_reg, result_next;

    logic                emit_valid;
    logic                emit_ready;
    tkcps_pkg::result_t  emit;
    tkcps_pkg::ram_req_t ram_req;
    tkcps_pkg::entry_t   ram_rdata;

    assign emit_ready = !result_valid_reg || result_ready;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (emit_ready)
        begin
            result_valid_next = emit_valid;
            result_next       = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_count_reg   <= tkcps_pkg::ROOT_COUNT_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                root_count_reg <= cfg_wr_data;
            end
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    tkcps_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .final_point (final_point),
        .root_count  (root_count_reg),
        .emit_valid  (emit_valid),
        .emit_ready  (emit_ready),
        .emit        (emit),
        .ram_req     (ram_req),
        .ram_rdata   (ram_rdata)
    );

    tkcps_ram #(
        .WIDTH (tkcps_pkg::ENTRY_BITS),
        .DEPTH (tkcps_pkg::MAX_ROOTS)
    ) u_root_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    assign result_valid = result_valid_reg;
    assign out_x        = result_reg.x;
    assign out_y        = result_reg.y;
    assign is_root      = result_reg.is_root;
    assign run_end      = result_reg.run_end;

endmodule

// ===== tb/top_k_root_checker.sv =====
`timescale 1ns / 100ps
// Checker that predicts the leaves and roots emitted by the top-k Chebyshev point selector.
module top_k_root_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           point_valid,
    input  logic                           point_ready,
    input  tkcps_pkg::coord_t              point_x,
    input  tkcps_pkg::coord_t              point_y,
    input  logic                           final_point,
    input  logic                           result_valid,
    input  logic                           result_ready,
    input  tkcps_pkg::coord_t              out_x,
    input  tkcps_pkg::coord_t              out_y,
    input  logic                           is_root,
    input  logic                           run_end,
    input  logic                           cfg_wr_en,
    input  logic [tkcps_pkg::CFG_BITS-1:0] cfg_wr_data,
    output int                             fail_count,
    output int                             pending
);

    tkcps_pkg::coord_t              kept_x [tkcps_pkg::MAX_ROOTS];
    tkcps_pkg::coord_t              kept_y [tkcps_pkg::MAX_ROOTS];
    int                             kept;
    int                             low_idx;
    tkcps_pkg::norm_t               low_norm;
    logic [tkcps_pkg::CFG_BITS-1:0] keep_cfg;
    tkcps_pkg::result_t             expected_emits [$];
    tkcps_pkg::result_t             want;
    int                             mismatches;

    function automatic tkcps_pkg::norm_t abs_coord(tkcps_pkg::coord_t v);
        return (v < 0) ? tkcps_pkg::norm_t'(-int'(v)) : tkcps_pkg::norm_t'(v);
    endfunction

    function automatic tkcps_pkg::norm_t point_norm(tkcps_pkg::coord_t x,
                                                    tkcps_pkg::coord_t y);
        tkcps_pkg::norm_t ax;
        tkcps_pkg::norm_t ay;
        ax = abs_coord(x);
        ay = abs_coord(y);
        return (ax > ay) ? ax : ay;
    endfunction

    // Lowest-indexed kept entry with the smallest norm.
    function automatic void find_smallest();
        tkcps_pkg::norm_t n;
        low_idx = 0;
        low_norm = '0;
        if (kept == 0)
        begin
            return;
        end
        low_norm = point_norm(kept_x[0], kept_y[0]);
        for (int i = 1; i < kept; i++)
        begin
            n = point_norm(kept_x[i], kept_y[i]);
            if (n < low_norm)
            begin
                low_norm = n;
                low_idx = i;
            end
        end
    endfunction

    function automatic void emit(tkcps_pkg::coord_t x, tkcps_pkg::coord_t y, logic root);
        tkcps_pkg::result_t r;
        r.x = x;
        r.y = y;
        r.is_root = root;
        r.run_end = 1'b0;
        expected_emits = {expected_emits, r};
    endfunction

    function automatic void predict_emits(tkcps_pkg::coord_t x, tkcps_pkg::coord_t y,
                                          logic fin);
        int                 lim;
        int                 start_cnt;
        tkcps_pkg::result_t last;
        lim = (int'(keep_cfg) > tkcps_pkg::MAX_ROOTS) ? tkcps_pkg::MAX_ROOTS : int'(keep_cfg);
        start_cnt = expected_emits.size();
        if (kept < lim)
        begin
            kept_x[kept] = x;
            kept_y[kept] = y;
            kept++;
            find_smallest();
        end
        else if (kept == 0)
        begin
            emit(x, y, 1'b0);
        end
        else if (point_norm(x, y) > low_norm)
        begin
            emit(kept_x[low_idx], kept_y[low_idx], 1'b0);
            kept_x[low_idx] = x;
            kept_y[low_idx] = y;
            find_smallest();
        end
        else
        begin
            emit(x, y, 1'b0);
        end
        if (fin)
        begin
            for (int i = 0; i < kept; i++)
            begin
                emit(kept_x[i], kept_y[i], 1'b1);
            end
            kept = 0;
            low_idx = 0;
            low_norm = '0;
        end
        if (expected_emits.size() > start_cnt)
        begin
            last = expected_emits.pop_back();
            last.run_end = 1'b1;
            expected_emits = {expected_emits, last};
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept = 0;
            low_idx = 0;
            low_norm = '0;
            keep_cfg = tkcps_pkg::ROOT_COUNT_RESET;
            expected_emits.delete();
            mismatches = 0;
            pending <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_emits.size() == 0)
                begin
                    $error("unexpected result: out_x %0d out_y %0d is_root %0b run_end %0b",
                           out_x, out_y, is_root, run_end);
                    mismatches++;
                end
                else
                begin
                    want = expected_emits.pop_front();
                    if (out_x !== want.x)
                    begin
                        $error("out_x: expected %0d, got %0d", want.x, out_x);
                        mismatches++;
                    end
                    if (out_y !== want.y)
                    begin
                        $error("out_y: expected %0d, got %0d", want.y, out_y);
                        mismatches++;
                    end
                    if (is_root !== want.is_root)
                    begin
                        $error("is_root: expected %0b, got %0b", want.is_root, is_root);
                        mismatches++;
                    end
                    if (run_end !== want.run_end)
                    begin
                        $error("run_end: expected %0b, got %0b", want.run_end, run_end);
                        mismatches++;
                    end
                end
            end
            if (cfg_wr_en)
            begin
                keep_cfg = cfg_wr_data;
            end
            if (point_valid && point_ready)
            begin
                predict_emits(point_x, point_y, final_point);
            end
            pending <= expected_emits.size();
            fail_count <= mismatches;
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the top-k Chebyshev point selector: stimulus, idling and verdict.
module tb;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASE_POINTS = 23;
    localparam int MAX_RUN      = 36;

    logic                           clk;
    logic                           rst_n;
    logic                           point_valid;
    logic                           point_ready;
    tkcps_pkg::coord_t              point_x;
    tkcps_pkg::coord_t              point_y;
    logic                           final_point;
    logic                           result_valid;
    logic                           result_ready;
    tkcps_pkg::coord_t              out_x;
    tkcps_pkg::coord_t              out_y;
    logic                           is_root;
    logic                           run_end;
    logic                           cfg_wr_en;
    logic [tkcps_pkg::CFG_BITS-1:0] cfg_wr_data;

    int fail_count;
    int pending;
    int cycles;
    int send_idle_pct;
    int stall_pct;

    int send_idle_by_mode [4] = '{0, 85, 0, 30};
    int stall_by_mode     [4] = '{0, 0, 85, 30};

    top_k_chebyshev_point_selector u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_ready  (point_ready),
        .point_x      (point_x),
        .point_y      (point_y),
        .final_point  (final_point),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_x        (out_x),
        .out_y        (out_y),
        .is_root      (is_root),
        .run_end      (run_end),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    top_k_root_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_ready  (point_ready),
        .point_x      (point_x),
        .point_y      (point_y),
        .final_point  (final_point),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_x        (out_x),
        .out_y        (out_y),
        .is_root      (is_root),
        .run_end      (run_end),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic tkcps_pkg::coord_t rand_coord();
        case ($urandom_range(9))
            0: return tkcps_pkg::coord_t'(16'h8000);
            1: return tkcps_pkg::coord_t'(16'h7fff);
            2, 3, 4: return tkcps_pkg::coord_t'(int'($urandom_range(8)) - 4);
            default: return tkcps_pkg::coord_t'($urandom);
        endcase
    endfunction

    task automatic send_point(input int x, input int y, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            point_valid <= 1'b0;
            @(posedge clk);
        end
        point_valid <= 1'b1;
        point_x <= tkcps_pkg::coord_t'(x);
        point_y <= tkcps_pkg::coord_t'(y);
        final_point <= fin;
        @(posedge clk);
        while (!point_ready)
        begin
            @(posedge clk);
        end
    endtask

    // The block may still be storing a point that causes no result, so give it time.
    task automatic wait_idle();
        point_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_root_count(input int value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= tkcps_pkg::CFG_BITS'(value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        int   rc;
        int   run_left;
        logic fin;

        rst_n = 1'b0;
        point_valid = 1'b0;
        point_x = '0;
        point_y = '0;
        final_point = 1'b0;
        result_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default of four roots: fill, evictions, an equal norm that does not evict, flush.
        send_point(0, 0, 1'b0);
        send_point(32767, -32768, 1'b0);
        send_point(-32768, 32767, 1'b0);
        send_point(-1, 1, 1'b0);
        send_point(5, -5, 1'b0);
        send_point(1, -1, 1'b0);
        send_point(-32768, -32768, 1'b0);
        send_point(0, -32767, 1'b0);
        send_point(2, 3, 1'b1);

        // With no roots every point leaves as a leaf and the flush adds nothing.
        wait_idle();
        write_root_count(0);
        send_point(7, -3, 1'b0);
        send_point(-32768, 0, 1'b1);

        // A count above the table depth; the run ends while the table is still filling.
        wait_idle();
        write_root_count(31);
        send_point(9, 9, 1'b0);
        send_point(-2, 4, 1'b0);
        send_point(0, 0, 1'b1);
        send_point(-1, -32768, 1'b1);

        // Count lowered and then raised in the middle of a run.
        wait_idle();
        write_root_count(4);
        send_point(10, 0, 1'b0);
        send_point(20, 0, 1'b0);
        send_point(30, 0, 1'b0);
        wait_idle();
        write_root_count(2);
        send_point(25, 1, 1'b0);
        send_point(15, 15, 1'b0);
        wait_idle();
        write_root_count(5);
        send_point(1, 1, 1'b0);
        send_point(40, 40, 1'b0);
        send_point(-3, 0, 1'b1);

        // Random runs; a run may span a change of the count.
        run_left = $urandom_range(1, MAX_RUN);
        for (int ph = 0; ph < 8; ph++)
        begin
            wait_idle();
            case (ph)
                0: rc = 1;
                1: rc = 16;
                2: rc = 17;
                3: rc = 31;
                4: rc = 0;
                5: rc = 2;
                6: rc = 8;
                default: rc = $urandom_range(0, 31);
            endcase
            write_root_count(rc);
            send_idle_pct = send_idle_by_mode[ph % 4];
            stall_pct = stall_by_mode[ph % 4];
            for (int n = 0; n < PHASE_POINTS; n++)
            begin
                run_left--;
                fin = (run_left == 0);
                send_point(int'(rand_coord()), int'(rand_coord()), fin);
                if (fin)
                begin
                    run_left = $urandom_range(1, MAX_RUN);
                end
            end
        end
        send_point(int'(rand_coord()), int'(rand_coord()), 1'b1);
        wait_idle();

        if (fail_count == 0 && pending == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
